// File: rtl/imuwr_pkg.sv
// shared types and constants of the imu window resampler
package imuwr_pkg;

	localparam int CH_BITS     = 32;
	localparam int CFG_BITS    = 48;
	localparam int INDEX_BITS  = 24;
	localparam int COUNT_BITS  = 25;
	localparam int RESUME_BITS = 26;
	localparam int RATIO_BITS  = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic signed [RESUME_BITS:0] RESUME_MAX = 27'sd33554431;
	localparam logic signed [RESUME_BITS:0] RESUME_BIAS = 27'sd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_INDEX  = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_INSIDE,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_BOUND,
		ST_DIV,
		ST_MSTART,
		ST_MUL,
		ST_PUSH_B,
		ST_PUSH_C,
		ST_END,
		ST_UPDATE
	} state_t;

endpackage

// File: rtl/imuwr_div.sv
// bit-serial restoring divider giving the rounded q0.16 interpolation ratio
module imuwr_div #(
	parameter int TIME_BITS = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [TIME_BITS-1:0]               num,
	input  logic [TIME_BITS-1:0]               den,
	output logic                               busy,
	output logic                               done,
	output logic [imuwr_pkg::RATIO_BITS-1:0]   ratio
);

	localparam int QB = imuwr_pkg::RATIO_BITS + 1;
	localparam int CB = $clog2(QB);

	logic                  busy_q;
	logic                  done_q;
	logic [CB-1:0]         cnt_q;
	logic [TIME_BITS-1:0]  rem_q;
	logic [TIME_BITS-1:0]  den_q;
	logic [QB-1:0]         quo_q;
	logic [imuwr_pkg::RATIO_BITS-1:0] ratio_q;

	logic [TIME_BITS:0]    sh;
	logic [TIME_BITS:0]    sub;
	logic                  ge;
	logic [QB-1:0]         nq;
	logic [QB:0]           rnd;

	always_comb begin
		sh  = {rem_q, 1'b0};
		sub = sh - {1'b0, den_q};
		ge  = sh >= {1'b0, den_q};
		nq  = {quo_q[QB-2:0], ge};
		rnd = ({1'b0, nq} + (QB+1)'(1)) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CB'(1);
				if (cnt_q == CB'(QB-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
			if (num >= den)
				ratio_q <= '1;
		end else if (busy_q) begin
			rem_q <= ge ? sub[TIME_BITS-1:0] : sh[TIME_BITS-1:0];
			quo_q <= nq;
			if (cnt_q == CB'(QB-1))
				ratio_q <= rnd[QB-1] ? '1 : rnd[imuwr_pkg::RATIO_BITS-1:0];
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign ratio = ratio_q;

endmodule

// File: rtl/imuwr_mul.sv
// shift-add multiplier for one channel: c + round((p - c) * r / 65536)
module imuwr_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [imuwr_pkg::CH_BITS:0]       diff,
	input  logic [imuwr_pkg::CH_BITS-1:0]     coef,
	input  logic [imuwr_pkg::RATIO_BITS-1:0]  ratio,
	output logic                              done,
	output logic [imuwr_pkg::CH_BITS-1:0]     res
);

	localparam int RB = imuwr_pkg::RATIO_BITS;
	localparam int CB = imuwr_pkg::CH_BITS;
	localparam int AB = CB + 1 + RB;
	localparam int NB = $clog2(RB);

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic [NB-1:0]    cnt_q;
	logic [AB-1:0]    mcand_q;
	logic [AB-1:0]    acc_q;
	logic [RB-1:0]    rsh_q;
	logic [CB-1:0]    c_q;
	logic [CB-1:0]    res_q;
	logic [AB-1:0]    rnd;

	// round half up before dropping the sixteen fraction bits
	assign rnd = acc_q + AB'(1 << (RB-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NB'(1);
				if (cnt_q == NB'(RB-1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= {{RB{diff[CB]}}, diff};
			acc_q   <= '0;
			rsh_q   <= ratio;
			c_q     <= coef;
		end else if (busy_q) begin
			if (rsh_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			rsh_q   <= rsh_q >> 1;
		end else if (fin_q) begin
			res_q <= c_q + rnd[RB +: CB];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: rtl/imu_window_resampler.sv
// top level of the imu window resampler
//
// usage
//   s_* carries one transaction per imu sample or end-of-data mark: tdata holds the
//   timestamp and the six channels, tuser the operation (0 sample, 1 end of data).
//   cfg_* writes window_start (0), window_end (1) and start_index (2); cfg_ready is
//   always high. the user writes only while idle; the block does not enforce it.
//   m_* carries results: tdata holds time, channels and resume index, tuser the
//   interpolated flag, tlast the final sample of the window.
// sequence
//   an item with no boundary on it goes through decide, an optional push and
//   update; a boundary item with a usable previous sample adds the 17-step serial
//   divider and, per channel, the 16-step serial multiplier. one item at a time.
//   one output is held back, so a result appears when the next output (or the
//   end-of-data mark) displaces it; the window's closing sample goes out at once.
// reset and stall
//   arst_n clears phase, counters and held output; the window registers return
//   to 0 and all ones. when m_tready is low the single output register holds
//   its transaction and the sequencer waits at the next step that emits.
module imu_window_resampler #(
	parameter int CHANNELS  = 6,
	parameter int TIME_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	// in_time, in_gyro_x .. in_accel_z (channels in order), zero pad
	input  logic [((TIME_BITS + CHANNELS*imuwr_pkg::CH_BITS + 7)/8)*8-1:0] s_tdata,
	// operation
	input  logic [0:0] s_tuser,
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	// out_time, out_gyro_x .. out_accel_z, resume_index, zero pad
	output logic [((TIME_BITS + CHANNELS*imuwr_pkg::CH_BITS + imuwr_pkg::RESUME_BITS
		+ 7)/8)*8-1:0] m_tdata,
	// interpolated
	output logic [0:0] m_tuser,
	output logic m_tlast,
	// configuration write channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [imuwr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [imuwr_pkg::CFG_BITS-1:0] cfg_data
);

	localparam int CB  = imuwr_pkg::CH_BITS;
	localparam int RB  = imuwr_pkg::RESUME_BITS;
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OW  = ((TIME_BITS + CHANNELS*CB + RB + 7)/8)*8;

	// configuration
	logic [imuwr_pkg::CFG_BITS-1:0]   ws_q;
	logic [imuwr_pkg::CFG_BITS-1:0]   we_q;
	logic [imuwr_pkg::INDEX_BITS-1:0] si_q;

	// accepted item
	logic                  op_q;
	logic [TIME_BITS-1:0]  t_q;
	logic [CB-1:0]         cur_q [CHANNELS];

	// block state
	imuwr_pkg::state_t     state_q, state_d;
	imuwr_pkg::phase_t     phase_q;
	logic [TIME_BITS-1:0]  prev_t_q;
	logic [CB-1:0]         prev_q [CHANNELS];
	logic                  have_prev_q;
	logic [TIME_BITS-1:0]  held_t_q;
	logic [CB-1:0]         held_q [CHANNELS];
	logic                  held_valid_q;
	logic                  held_interp_q;
	logic [imuwr_pkg::COUNT_BITS-1:0] count_q;

	// boundary sample
	logic [TIME_BITS-1:0]  bt_q;
	logic [CB-1:0]         bch_q [CHANNELS];
	logic [CW-1:0]         ch_q;

	// output register
	logic                  o_valid_q;
	logic [TIME_BITS-1:0]  o_t_q;
	logic [CB-1:0]         o_ch_q [CHANNELS];
	logic                  o_interp_q;
	logic                  o_last_q;
	logic [RB-1:0]         o_resume_q;

	// control
	logic                  out_free;
	logic                  emit;
	logic                  emit_last;
	logic                  div_start;
	logic                  mul_start;
	logic                  accept;
	logic                  div_busy;
	logic                  div_done;
	logic [imuwr_pkg::RATIO_BITS-1:0] ratio;
	logic                  mul_done;
	logic [CB-1:0]         mul_res;
	logic [CB:0]           mul_diff;
	logic [TIME_BITS-1:0]  ws_t;
	logic [TIME_BITS-1:0]  we_t;
	logic [TIME_BITS-1:0]  tgt;
	logic                  use_prev;
	logic                  ch_last;
	logic signed [RB:0]    resume_sum;
	logic [RB-1:0]         resume;

	assign ws_t     = TIME_BITS'(ws_q);
	assign we_t     = TIME_BITS'(we_q);
	assign tgt      = (phase_q == imuwr_pkg::PH_BEFORE) ? ws_t : we_t;
	assign use_prev = have_prev_q && (t_q > prev_t_q);
	assign ch_last  = ch_q == CW'(CHANNELS-1);
	assign out_free = !o_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mul_diff = {prev_q[ch_q][CB-1], prev_q[ch_q]} - {cur_q[ch_q][CB-1], cur_q[ch_q]};

	// resume hint: start_index + consumed - 3, clipped above at 33554431 (2^25 - 1)
	always_comb begin
		resume_sum = $signed({3'b000, si_q}) + $signed({2'b00, count_q}) - imuwr_pkg::RESUME_BIAS;
		resume     = (resume_sum > imuwr_pkg::RESUME_MAX) ? imuwr_pkg::RESUME_MAX[RB-1:0]
			: resume_sum[RB-1:0];
	end

	imuwr_div #(
		.TIME_BITS(TIME_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (t_q - tgt),
		.den   (t_q - prev_t_q),
		.busy  (div_busy),
		.done  (div_done),
		.ratio (ratio)
	);

	imuwr_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.diff  (mul_diff),
		.coef  (cur_q[ch_q]),
		.ratio (ratio),
		.done  (mul_done),
		.res   (mul_res)
	);

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		unique case (state_q)
			imuwr_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = imuwr_pkg::ST_DECIDE;
			end
			imuwr_pkg::ST_DECIDE: begin
				if (phase_q == imuwr_pkg::PH_DONE) begin
					state_d = imuwr_pkg::ST_IDLE;
				end else if (op_q == imuwr_pkg::OP_FLUSH) begin
					if (!held_valid_q || out_free) begin
						emit    = held_valid_q;
						state_d = imuwr_pkg::ST_IDLE;
					end
				end else if (phase_q == imuwr_pkg::PH_BEFORE) begin
					state_d = (t_q >= ws_t) ? imuwr_pkg::ST_BOUND : imuwr_pkg::ST_UPDATE;
				end else begin
					state_d = (t_q < we_t) ? imuwr_pkg::ST_PUSH_C : imuwr_pkg::ST_BOUND;
				end
			end
			imuwr_pkg::ST_BOUND: begin
				div_start = use_prev;
				state_d   = use_prev ? imuwr_pkg::ST_DIV : imuwr_pkg::ST_PUSH_B;
			end
			imuwr_pkg::ST_DIV: begin
				if (div_done)
					state_d = imuwr_pkg::ST_MSTART;
			end
			imuwr_pkg::ST_MSTART: begin
				mul_start = 1'b1;
				state_d   = imuwr_pkg::ST_MUL;
			end
			imuwr_pkg::ST_MUL: begin
				if (mul_done)
					state_d = ch_last ? imuwr_pkg::ST_PUSH_B : imuwr_pkg::ST_MSTART;
			end
			imuwr_pkg::ST_PUSH_B: begin
				if (!(held_valid_q && bt_q > held_t_q) || out_free) begin
					emit = held_valid_q && bt_q > held_t_q;
					if (phase_q == imuwr_pkg::PH_INSIDE)
						state_d = imuwr_pkg::ST_END;
					else if (t_q > ws_t)
						state_d = imuwr_pkg::ST_PUSH_C;
					else
						state_d = imuwr_pkg::ST_UPDATE;
				end
			end
			imuwr_pkg::ST_PUSH_C: begin
				if (!(held_valid_q && t_q > held_t_q) || out_free) begin
					emit    = held_valid_q && t_q > held_t_q;
					state_d = imuwr_pkg::ST_UPDATE;
				end
			end
			imuwr_pkg::ST_END: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = imuwr_pkg::ST_UPDATE;
				end
			end
			imuwr_pkg::ST_UPDATE: begin
				state_d = imuwr_pkg::ST_IDLE;
			end
			default: state_d = imuwr_pkg::ST_IDLE;
		endcase
	end

	assign s_tready  = state_q == imuwr_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= imuwr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q          <= '0;
			we_q          <= '1;
			si_q          <= '0;
			phase_q       <= imuwr_pkg::PH_BEFORE;
			have_prev_q   <= 1'b0;
			held_valid_q  <= 1'b0;
			held_interp_q <= 1'b0;
			count_q       <= '0;
			ch_q          <= '0;
			o_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					imuwr_pkg::REG_WINDOW_START: ws_q <= cfg_data;
					imuwr_pkg::REG_WINDOW_END:   we_q <= cfg_data;
					imuwr_pkg::REG_START_INDEX:  si_q <= cfg_data[imuwr_pkg::INDEX_BITS-1:0];
					default: ;
				endcase
			end
			if (emit)
				o_valid_q <= 1'b1;
			else if (m_tready)
				o_valid_q <= 1'b0;
			unique case (state_q)
				imuwr_pkg::ST_DECIDE: begin
					if (phase_q != imuwr_pkg::PH_DONE && op_q == imuwr_pkg::OP_FLUSH &&
						(!held_valid_q || out_free)) begin
						held_valid_q <= 1'b0;
						phase_q      <= imuwr_pkg::PH_DONE;
					end
				end
				imuwr_pkg::ST_DIV: begin
					ch_q <= '0;
				end
				imuwr_pkg::ST_MUL: begin
					if (mul_done && !ch_last)
						ch_q <= ch_q + CW'(1);
				end
				imuwr_pkg::ST_PUSH_B: begin
					if (state_d != imuwr_pkg::ST_PUSH_B) begin
						held_valid_q  <= 1'b1;
						held_interp_q <= 1'b1;
						if (phase_q == imuwr_pkg::PH_BEFORE)
							phase_q <= imuwr_pkg::PH_INSIDE;
					end
				end
				imuwr_pkg::ST_PUSH_C: begin
					if (state_d != imuwr_pkg::ST_PUSH_C) begin
						held_valid_q  <= 1'b1;
						held_interp_q <= 1'b0;
					end
				end
				imuwr_pkg::ST_END: begin
					if (out_free) begin
						held_valid_q <= 1'b0;
						phase_q      <= imuwr_pkg::PH_DONE;
					end
				end
				imuwr_pkg::ST_UPDATE: begin
					have_prev_q <= 1'b1;
					if (count_q != imuwr_pkg::COUNT_MAX)
						count_q <= count_q + imuwr_pkg::COUNT_BITS'(1);
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tuser[0];
			t_q  <= s_tdata[TIME_BITS-1:0];
			for (int k = 0; k < CHANNELS; k++)
				cur_q[k] <= s_tdata[TIME_BITS + k*CB +: CB];
		end
		if (state_q == imuwr_pkg::ST_BOUND && !use_prev) begin
			bt_q <= t_q;
			for (int k = 0; k < CHANNELS; k++)
				bch_q[k] <= cur_q[k];
		end
		if (state_q == imuwr_pkg::ST_MUL && mul_done) begin
			bch_q[ch_q] <= mul_res;
			bt_q        <= tgt;
		end
		if (emit) begin
			o_t_q      <= held_t_q;
			o_interp_q <= held_interp_q;
			o_last_q   <= emit_last;
			o_resume_q <= emit_last ? resume : '0;
			for (int k = 0; k < CHANNELS; k++)
				o_ch_q[k] <= held_q[k];
		end
		if (state_q == imuwr_pkg::ST_PUSH_B && state_d != imuwr_pkg::ST_PUSH_B) begin
			held_t_q <= bt_q;
			for (int k = 0; k < CHANNELS; k++)
				held_q[k] <= bch_q[k];
		end
		if (state_q == imuwr_pkg::ST_PUSH_C && state_d != imuwr_pkg::ST_PUSH_C) begin
			held_t_q <= t_q;
			for (int k = 0; k < CHANNELS; k++)
				held_q[k] <= cur_q[k];
		end
		if (state_q == imuwr_pkg::ST_UPDATE) begin
			prev_t_q <= t_q;
			for (int k = 0; k < CHANNELS; k++)
				prev_q[k] <= cur_q[k];
		end
	end

	// output packing
	always_comb begin
		m_tdata = '0;
		m_tdata[TIME_BITS-1:0] = o_t_q;
		for (int k = 0; k < CHANNELS; k++)
			m_tdata[TIME_BITS + k*CB +: CB] = o_ch_q[k];
		m_tdata[TIME_BITS + CHANNELS*CB +: RB] = o_resume_q;
	end

	assign m_tvalid   = o_valid_q;
	assign m_tuser[0] = o_interp_q;
	assign m_tlast    = o_last_q;

	// the closing sample of the window is always a boundary sample
	a_last_interp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("last sample of window not interpolated");

	// only the closing sample carries a resume hint
	a_resume_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[TIME_BITS + CHANNELS*CB +: RB] == '0)
		else $error("resume hint on a sample that is not last");

	// the divider only runs while a boundary is being worked out
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == imuwr_pkg::ST_DIV)
		else $error("divider busy outside its step");

	// an accepted item is always examined next
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == imuwr_pkg::ST_DECIDE)
		else $error("accepted item not taken to the decision step");

endmodule

// File: test/tb.sv
// self-checking testbench for the imu window resampler
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH       = 6;
	localparam int TBITS     = 48;
	localparam int SDATA_W   = ((TBITS + NCH*imuwr_pkg::CH_BITS + 7)/8)*8;
	localparam int MDATA_W   =
		((TBITS + NCH*imuwr_pkg::CH_BITS + imuwr_pkg::RESUME_BITS + 7)/8)*8;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [TBITS-1:0] TIME_ALL_ONES = '1;

	typedef struct {
		logic                  op;
		logic [TBITS-1:0]      stamp;
		logic signed [31:0]    ch [NCH];
	} imu_item_t;

	typedef struct {
		logic [TBITS-1:0]      stamp;
		logic signed [31:0]    ch [NCH];
		logic                  interp;
		logic                  last;
		logic [imuwr_pkg::RESUME_BITS-1:0] resume;
	} imu_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [SDATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [MDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [imuwr_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [imuwr_pkg::CFG_BITS-1:0] cfg_data;

	imu_window_resampler #(.CHANNELS(NCH), .TIME_BITS(TBITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the configuration registers
	logic [TBITS-1:0] win_start_q;
	logic [TBITS-1:0] win_end_q;
	logic [imuwr_pkg::INDEX_BITS-1:0] start_idx_q;

	// shadow of the block state
	logic [TBITS-1:0] prev_stamp;
	logic signed [31:0] prev_ch [NCH];
	logic prev_seen;
	logic [TBITS-1:0] held_stamp;
	logic signed [31:0] held_ch [NCH];
	logic held_full;
	logic held_interp;
	imuwr_pkg::phase_t win_phase;
	logic [imuwr_pkg::COUNT_BITS-1:0] taken_count;

	imu_item_t   pending_samples [$];
	imu_result_t awaited_samples [$];
	imu_item_t   cur_item;

	int errors = 0;
	int items_taken = 0;
	int results_seen = 0;
	int interp_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold = 0;
	int idle_cycles = 0;
	logic [TBITS-1:0] last_stamp = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// q0.16 ratio of num/den, rounded half up, saturating
	function automatic logic [imuwr_pkg::RATIO_BITS-1:0] lerp_ratio(
		input logic [TBITS-1:0] num, input logic [TBITS-1:0] den);
		logic [65:0] q;
		if (den == 0)
			return '0;
		if (num >= den)
			return 16'hffff;
		q = ({18'd0, num} << 17) / {18'd0, den};
		q = (q + 1) >> 1;
		return (q > 66'd65535) ? 16'hffff : q[15:0];
	endfunction

	function automatic logic signed [31:0] lerp_channel(input logic signed [31:0] p,
		input logic signed [31:0] c, input logic [imuwr_pkg::RATIO_BITS-1:0] r);
		longint diff;
		longint prod;
		longint res;
		diff = longint'(p) - longint'(c);
		prod = diff * longint'({1'b0, r});
		res = longint'(c) + ((prod + 32768) >>> 16);
		return res[31:0];
	endfunction

	// boundary sample at target, interpolated from the previous sample, else the item itself
	task automatic boundary_sample(input logic [TBITS-1:0] target, input imu_item_t it,
		output imu_result_t b);
		logic [imuwr_pkg::RATIO_BITS-1:0] r;
		if (prev_seen && it.stamp > prev_stamp) begin
			r = lerp_ratio(it.stamp - target, it.stamp - prev_stamp);
			b.stamp = target;
			foreach (b.ch[k]) b.ch[k] = lerp_channel(prev_ch[k], it.ch[k], r);
		end else begin
			b.stamp = it.stamp;
			foreach (b.ch[k]) b.ch[k] = it.ch[k];
		end
	endtask

	task automatic emit_held(input logic last,
		input logic [imuwr_pkg::RESUME_BITS-1:0] resume);
		imu_result_t e;
		e.stamp = held_stamp;
		foreach (e.ch[k]) e.ch[k] = held_ch[k];
		e.interp = held_interp;
		e.last = last;
		e.resume = resume;
		awaited_samples = {awaited_samples, e};
	endtask

	// a newer output releases the held one only if it is strictly later
	task automatic hold_output(input logic [TBITS-1:0] stamp,
		input logic signed [31:0] ch [NCH], input logic interp);
		if (held_full && stamp > held_stamp)
			emit_held(1'b0, '0);
		held_stamp = stamp;
		foreach (held_ch[k]) held_ch[k] = ch[k];
		held_interp = interp;
		held_full = 1'b1;
	endtask

	task automatic predict_window(input imu_item_t it);
		imu_result_t b;
		longint resume;
		if (win_phase == imuwr_pkg::PH_DONE)
			return;
		if (it.op == imuwr_pkg::OP_FLUSH) begin
			if (held_full)
				emit_held(1'b0, '0);
			held_full = 1'b0;
			win_phase = imuwr_pkg::PH_DONE;
			return;
		end
		if (win_phase == imuwr_pkg::PH_BEFORE) begin
			if (it.stamp >= win_start_q) begin
				boundary_sample(win_start_q, it, b);
				hold_output(b.stamp, b.ch, 1'b1);
				if (it.stamp > win_start_q)
					hold_output(it.stamp, it.ch, 1'b0);
				win_phase = imuwr_pkg::PH_INSIDE;
			end
		end else if (it.stamp < win_end_q) begin
			hold_output(it.stamp, it.ch, 1'b0);
		end else begin
			boundary_sample(win_end_q, it, b);
			hold_output(b.stamp, b.ch, 1'b1);
			resume = longint'(start_idx_q) + longint'(taken_count) - 3;
			if (resume > 33554431)
				resume = 33554431;
			emit_held(1'b1, resume[imuwr_pkg::RESUME_BITS-1:0]);
			held_full = 1'b0;
			win_phase = imuwr_pkg::PH_DONE;
		end
		prev_stamp = it.stamp;
		foreach (prev_ch[k]) prev_ch[k] = it.ch[k];
		prev_seen = 1'b1;
		if (taken_count != imuwr_pkg::COUNT_MAX)
			taken_count++;
	endtask

	// driver: one transaction per accepted item, prediction at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_window(cur_item);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_item.op;
					s_tdata <= {cur_item.ch[5], cur_item.ch[4], cur_item.ch[3],
						cur_item.ch[2], cur_item.ch[1], cur_item.ch[0], cur_item.stamp};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		imu_result_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_samples.size() == 0) begin
					$display("unexpected result transaction at %0t", $realtime);
					errors++;
				end else begin
					w = awaited_samples.pop_front();
					if (w.interp)
						interp_seen++;
					if (m_tdata[TBITS-1:0] !== w.stamp)
						report("out_time", m_tdata[TBITS-1:0], w.stamp);
					for (int k = 0; k < NCH; k++)
						if (m_tdata[TBITS + 32*k +: 32] !== w.ch[k])
							report($sformatf("channel %0d", k),
								m_tdata[TBITS + 32*k +: 32], w.ch[k]);
					if (m_tdata[TBITS + 32*NCH +: imuwr_pkg::RESUME_BITS] !== w.resume)
						report("resume_index",
							m_tdata[TBITS + 32*NCH +: imuwr_pkg::RESUME_BITS], w.resume);
					if (m_tuser[0] !== w.interp)
						report("interpolated", m_tuser[0], w.interp);
					if (m_tlast !== w.last)
						report("last_of_window", m_tlast, w.last);
				end
			end
			// long hold-off so the block fills and back-pressures its input
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [imuwr_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [imuwr_pkg::CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			imuwr_pkg::REG_WINDOW_START: win_start_q = val;
			imuwr_pkg::REG_WINDOW_END:   win_end_q = val;
			imuwr_pkg::REG_START_INDEX:  start_idx_q = val[imuwr_pkg::INDEX_BITS-1:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] rand_channel();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_sample(input logic [TBITS-1:0] stamp, input logic signed [31:0] c0,
		input logic signed [31:0] c1, input bit random_ch);
		imu_item_t it;
		it.op = imuwr_pkg::OP_SAMPLE;
		it.stamp = stamp;
		foreach (it.ch[k])
			it.ch[k] = random_ch ? rand_channel() : ((k % 2) ? c1 : c0);
		last_stamp = stamp;
		pending_samples = {pending_samples, it};
	endtask

	// mostly advancing timestamps, some repeats, some stepping back, some anywhere
	task automatic queue_random_samples(input int n);
		logic [TBITS-1:0] t;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 70)
				t = last_stamp + TBITS'($urandom_range(1, 5000));
			else if (sel < 80)
				t = last_stamp;
			else if (sel < 90)
				t = last_stamp - TBITS'($urandom_range(0, 1000));
			else
				t = TBITS'({$urandom, $urandom});
			if (t == TIME_ALL_ONES)
				t = t - 1;
			queue_sample(t, 0, 0, 1'b1);
		end
	endtask

	// all queued items accepted and every awaited result received
	task automatic drain();
		while (pending_samples.size() > 0 || s_tvalid || awaited_samples.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		imu_item_t fl;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		win_start_q = '0;
		win_end_q = '1;
		start_idx_q = '0;
		prev_stamp = '0;
		prev_seen = 1'b0;
		held_stamp = '0;
		held_full = 1'b0;
		held_interp = 1'b0;
		win_phase = imuwr_pkg::PH_BEFORE;
		taken_count = '0;
		foreach (prev_ch[k]) begin
			prev_ch[k] = '0;
			held_ch[k] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(imuwr_pkg::REG_WINDOW_START, 48'd1_000_000);
		write_reg(imuwr_pkg::REG_WINDOW_END, '1);
		write_reg(imuwr_pkg::REG_START_INDEX, 48'hff_ffff);

		// directed: samples before the window, then a start crossing between extremes
		queue_sample(48'd0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		queue_sample(48'd400_000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		queue_sample(48'd999_999, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		queue_sample(48'd1_300_000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		// repeated time drops the held output, earlier time too
		queue_sample(48'd1_300_000, 32'sd0, -32'sd1, 1'b0);
		queue_sample(48'd1_200_000, 32'sd1, 32'sd65536, 1'b0);
		queue_sample(48'd2_000_000, -32'sd65536, 32'sd0, 1'b0);
		// near the top of the time range, then wrap back down
		queue_sample(TIME_ALL_ONES - 1, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0);
		queue_sample(48'h0000_0000_0001, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0);
		queue_sample(48'h8000_0000_0000, 32'sh0000_ffff, 32'shffff_0000, 1'b0);
		queue_sample(48'h8000_0000_0000 + 1, -32'sd1, 32'sd0, 1'b0);
		drain();

		// window start register written again while inside, index at its low extreme
		write_reg(imuwr_pkg::REG_WINDOW_START, '0);
		write_reg(imuwr_pkg::REG_START_INDEX, '0);
		send_idle_pct = 16;
		recv_idle_pct = 75;
		queue_random_samples(450);
		drain();

		write_reg(imuwr_pkg::REG_START_INDEX,
			imuwr_pkg::CFG_BITS'($urandom_range(0, 24'hff_ffff)));
		send_idle_pct = 75;
		recv_idle_pct = 16;
		queue_random_samples(450);
		drain();

		write_reg(imuwr_pkg::REG_START_INDEX, 48'hff_ffff);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold = 3000;
		queue_random_samples(450);
		drain();

		// end crossing with the window end below the previous time: ratio saturates
		write_reg(imuwr_pkg::REG_WINDOW_END, last_stamp - 5);
		queue_sample(last_stamp + 10, 0, 0, 1'b1);
		// once done, samples and an end-of-data mark are ignored
		queue_sample(last_stamp + 20, 0, 0, 1'b1);
		fl.op = imuwr_pkg::OP_FLUSH;
		fl.stamp = '0;
		foreach (fl.ch[k]) fl.ch[k] = '0;
		pending_samples = {pending_samples, fl};
		queue_sample(last_stamp + 30, 0, 0, 1'b1);
		drain();

		$display("covered %0d items and %0d results, %0d of them boundary samples,",
			items_taken, results_seen, interp_seen);
		$display("across three idle patterns, a long output stall and the window end");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
rtl/imuwr_pkg.sv
rtl/imuwr_div.sv
rtl/imuwr_mul.sv
rtl/imu_window_resampler.sv
test/tb.sv
